/* design/cts_pkg.sv */
`default_nettype none

package cts_pkg;

  localparam int MAX_TOKENS  = 4;
  localparam int TOK_CNT_W   = $clog2(MAX_TOKENS + 1);
  localparam int TOK_IDX_W   = $clog2(MAX_TOKENS);
  localparam int NUM_WORDS   = 5;
  localparam int WORD_LEN    = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SIGN    = 3'd1,
    MODE_ASSIGN  = 3'd2,
    MODE_KEYWORD = 3'd3,
    MODE_INT     = 3'd4,
    MODE_FRAC    = 3'd5
  } mode_e;

  typedef enum logic [3:0] {
    KIND_NUM_START = 4'd0,
    KIND_NUM_CHAR  = 4'd1,
    KIND_NUM_END   = 4'd2,
    KIND_SIN       = 4'd3,
    KIND_COS       = 4'd4,
    KIND_TAN       = 4'd5,
    KIND_EXP       = 4'd6,
    KIND_POW       = 4'd7,
    KIND_VAR       = 4'd8,
    KIND_ASSIGN    = 4'd9,
    KIND_OTHER     = 4'd10,
    KIND_EOF       = 4'd11
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } token_t;

  // all tokens caused by one input transfer
  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tok;
    logic [TOK_CNT_W-1:0]    n;
  } bundle_t;

  localparam logic [7:0] WORD_TEXT [NUM_WORDS][WORD_LEN] = '{
    '{8'h73, 8'h69, 8'h6e},
    '{8'h63, 8'h6f, 8'h73},
    '{8'h74, 8'h61, 8'h6e},
    '{8'h70, 8'h6f, 8'h77},
    '{8'h65, 8'h78, 8'h70}
  };

  localparam kind_e WORD_KIND [NUM_WORDS] = '{KIND_SIN, KIND_COS, KIND_TAN, KIND_POW, KIND_EXP};

endpackage

`default_nettype wire

/* design/cts_if.sv */
`default_nettype none

interface cts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

interface cts_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] token_char;
  logic       last;

  modport source (output valid, output token_kind, output token_char, output last, input ready);
  modport sink (input valid, input token_kind, input token_char, input last, output ready);
endinterface

`default_nettype wire

/* design/cts_front.sv */
`default_nettype none

module cts_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  cts_in_if.sink                in_i,
  output      logic             push_valid_o,
  output      cts_pkg::bundle_t push_data_o,
  input  wire logic             push_ready_i
);

  typedef struct packed {
    cts_pkg::mode_e mode;
    logic [7:0]     let0;
    logic [7:0]     let1;
    logic [1:0]     cnt;
    logic [7:0]     sign;
  } scan_state_t;

  typedef struct packed {
    scan_state_t      st;
    logic [1:0]       n;
    cts_pkg::token_t  t0;
    cts_pkg::token_t  t1;
    logic             again;
  } scan_res_t;

  localparam scan_state_t ST_RESET = '{
    mode: cts_pkg::MODE_IDLE, let0: 8'h00, let1: 8'h00, cnt: 2'd0, sign: 8'h00
  };

  function automatic cts_pkg::token_t mk_tok(cts_pkg::kind_e k, logic [7:0] c);
    cts_pkg::token_t t;
    t.kind = k;
    t.ch   = c;
    return t;
  endfunction

  function automatic cts_pkg::bundle_t push_tok(cts_pkg::bundle_t b, cts_pkg::token_t t);
    cts_pkg::bundle_t r;
    r = b;
    if (r.n < cts_pkg::TOK_CNT_W'(cts_pkg::MAX_TOKENS)) begin
      r.tok[r.n[cts_pkg::TOK_IDX_W-1:0]] = t;
      r.n = r.n + 1'b1;
    end
    return r;
  endfunction

  // pending keyword letters, capped at two
  function automatic scan_res_t flush_letters(scan_res_t r_in);
    scan_res_t r;
    r      = r_in;
    r.t0   = mk_tok(cts_pkg::KIND_OTHER, r.st.let0);
    r.t1   = mk_tok(cts_pkg::KIND_OTHER, r.st.let1);
    r.n    = (r.st.cnt[1]) ? 2'd2 : r.st.cnt;
    r.st.cnt = 2'd0;
    return r;
  endfunction

  function automatic scan_res_t scan_one(scan_state_t s, logic [7:0] c);
    scan_res_t      r;
    logic           is_dig;
    logic           is_word0;
    logic           match;
    cts_pkg::kind_e mk;
    r.st    = s;
    r.n     = 2'd0;
    r.t0    = mk_tok(cts_pkg::KIND_OTHER, cts_pkg::CH_NUL);
    r.t1    = mk_tok(cts_pkg::KIND_OTHER, cts_pkg::CH_NUL);
    r.again = 1'b0;
    is_dig  = (c >= cts_pkg::CH_ZERO) && (c <= cts_pkg::CH_NINE);
    match   = 1'b0;
    mk      = cts_pkg::KIND_OTHER;
    is_word0 = 1'b0;
    for (int k = 0; k < cts_pkg::NUM_WORDS; k++) begin
      if (cts_pkg::WORD_TEXT[k][0] == c) is_word0 = 1'b1;
      if (!match && ((s.cnt == 2'd1 && cts_pkg::WORD_TEXT[k][0] == s.let0 &&
                      cts_pkg::WORD_TEXT[k][1] == c) ||
                     (s.cnt == 2'd2 && cts_pkg::WORD_TEXT[k][0] == s.let0 &&
                      cts_pkg::WORD_TEXT[k][1] == s.let1 &&
                      cts_pkg::WORD_TEXT[k][2] == c))) begin
        match = 1'b1;
        mk    = cts_pkg::WORD_KIND[k];
      end
    end
    case (s.mode)
      cts_pkg::MODE_SIGN: begin
        if (is_dig || c == cts_pkg::CH_DOT) begin
          r.t0 = mk_tok(cts_pkg::KIND_NUM_START, s.sign);
          r.t1 = mk_tok(cts_pkg::KIND_NUM_CHAR, c);
          r.n  = 2'd2;
          r.st.mode = (c == cts_pkg::CH_DOT) ? cts_pkg::MODE_FRAC : cts_pkg::MODE_INT;
        end else begin
          r.t0 = mk_tok(cts_pkg::KIND_OTHER, s.sign);
          r.n  = 2'd1;
          r.st.mode = cts_pkg::MODE_IDLE;
          r.again = 1'b1;
        end
      end
      cts_pkg::MODE_ASSIGN: begin
        r.t0 = mk_tok(cts_pkg::KIND_ASSIGN, c);
        r.n  = 2'd1;
        r.st.mode = cts_pkg::MODE_IDLE;
      end
      cts_pkg::MODE_KEYWORD: begin
        if (match && s.cnt == 2'd2) begin
          r.t0 = mk_tok(mk, cts_pkg::CH_NUL);
          r.n  = 2'd1;
          r.st.cnt  = 2'd0;
          r.st.mode = cts_pkg::MODE_IDLE;
        end else if (match) begin
          r.st.let1 = c;
          r.st.cnt  = 2'd2;
        end else begin
          r = flush_letters(r);
          r.st.mode = cts_pkg::MODE_IDLE;
          r.again = 1'b1;
        end
      end
      cts_pkg::MODE_INT, cts_pkg::MODE_FRAC: begin
        if (is_dig || (s.mode == cts_pkg::MODE_INT && c == cts_pkg::CH_DOT)) begin
          r.t0 = mk_tok(cts_pkg::KIND_NUM_CHAR, c);
          r.n  = 2'd1;
          if (!is_dig) r.st.mode = cts_pkg::MODE_FRAC;
        end else begin
          r.t0 = mk_tok(cts_pkg::KIND_NUM_END, cts_pkg::CH_NUL);
          r.n  = 2'd1;
          r.st.mode = cts_pkg::MODE_IDLE;
          r.again = 1'b1;
        end
      end
      default: begin
        r.st.mode = cts_pkg::MODE_IDLE;
        if (c == cts_pkg::CH_SPACE || c == cts_pkg::CH_TAB) begin
          r.n = 2'd0;
        end else if (c == cts_pkg::CH_PLUS || c == cts_pkg::CH_MINUS) begin
          r.st.sign = c;
          r.st.mode = cts_pkg::MODE_SIGN;
        end else if (c >= cts_pkg::CH_UP_A && c <= cts_pkg::CH_UP_Z) begin
          r.t0 = mk_tok(cts_pkg::KIND_VAR, c);
          r.n  = 2'd1;
        end else if (c == cts_pkg::CH_EQ) begin
          r.st.mode = cts_pkg::MODE_ASSIGN;
        end else if (is_word0) begin
          r.st.let0 = c;
          r.st.cnt  = 2'd1;
          r.st.mode = cts_pkg::MODE_KEYWORD;
        end else if (is_dig || c == cts_pkg::CH_DOT) begin
          r.t0 = mk_tok(cts_pkg::KIND_NUM_START, cts_pkg::CH_PLUS);
          r.t1 = mk_tok(cts_pkg::KIND_NUM_CHAR, c);
          r.n  = 2'd2;
          r.st.mode = (c == cts_pkg::CH_DOT) ? cts_pkg::MODE_FRAC : cts_pkg::MODE_INT;
        end else begin
          r.t0 = mk_tok(cts_pkg::KIND_OTHER, c);
          r.n  = 2'd1;
        end
      end
    endcase
    return r;
  endfunction

  scan_state_t      state_q, state_d;
  cts_pkg::bundle_t bun;
  scan_res_t        res;
  logic             again;
  logic             in_fire;

  assign in_i.ready = push_ready_i;
  assign in_fire    = in_i.valid && push_ready_i;

  always_comb begin
    state_d = state_q;
    bun     = '0;
    res     = '0;
    again   = 1'b1;
    if (in_i.end_of_input) begin
      case (state_q.mode)
        cts_pkg::MODE_SIGN: bun = push_tok(bun, mk_tok(cts_pkg::KIND_OTHER, state_q.sign));
        cts_pkg::MODE_ASSIGN: bun = push_tok(bun, mk_tok(cts_pkg::KIND_ASSIGN, cts_pkg::CH_NUL));
        cts_pkg::MODE_KEYWORD: begin
          res.st = state_q;
          res = flush_letters(res);
          if (res.n != 2'd0) bun = push_tok(bun, res.t0);
          if (res.n == 2'd2) bun = push_tok(bun, res.t1);
        end
        cts_pkg::MODE_INT, cts_pkg::MODE_FRAC:
          bun = push_tok(bun, mk_tok(cts_pkg::KIND_NUM_END, cts_pkg::CH_NUL));
        default: bun = bun;
      endcase
      bun     = push_tok(bun, mk_tok(cts_pkg::KIND_EOF, cts_pkg::CH_NUL));
      state_d = ST_RESET;
    end else begin
      // a character can be rescanned after a sign, keyword or number ends
      for (int p = 0; p < 3; p++) begin
        if (again) begin
          res     = scan_one(state_d, in_i.char_in);
          state_d = res.st;
          again   = res.again;
          if (res.n != 2'd0) bun = push_tok(bun, res.t0);
          if (res.n == 2'd2) bun = push_tok(bun, res.t1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RESET;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  assign push_valid_o = in_fire && (bun.n != '0);
  assign push_data_o  = bun;

`ifndef NO_ASSERTIONS
  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.end_of_input |=> state_q.mode == cts_pkg::MODE_IDLE && state_q.cnt == 2'd0)
    else $error("scanner not idle after end of input");
  a_blank_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_i.end_of_input && state_q.mode == cts_pkg::MODE_IDLE &&
    (in_i.char_in == cts_pkg::CH_SPACE || in_i.char_in == cts_pkg::CH_TAB) |-> !push_valid_o)
    else $error("blank produced a token");
`endif

endmodule

`default_nettype wire

/* design/cts_fifo.sv */
`default_nettype none

module cts_fifo #(
  parameter int Depth = cts_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output      logic             wr_ready_o,
  input  wire cts_pkg::bundle_t wr_data_i,
  output      logic             rd_valid_o,
  input  wire logic             rd_ready_i,
  output      cts_pkg::bundle_t rd_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cts_pkg::bundle_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count out of range");
  a_count_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count lost a transfer");
`endif

endmodule

`default_nettype wire

/* design/cts_back.sv */
`default_nettype none

module cts_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pop_valid_i,
  output      logic             pop_ready_o,
  input  wire cts_pkg::bundle_t pop_data_i,
  cts_out_if.source             out_o
);

  cts_pkg::bundle_t                 cur_q;
  logic [cts_pkg::TOK_IDX_W-1:0]    idx_q;
  logic                             busy_q;
  logic                             is_last;
  logic                             out_fire;
  logic                             done;
  logic                             load;
  cts_pkg::token_t                  tok;

  assign tok      = cur_q.tok[idx_q];
  assign is_last  = (cts_pkg::TOK_CNT_W'(idx_q) + 1'b1) == cur_q.n;
  assign out_fire = busy_q && out_o.ready;
  assign done     = out_fire && is_last;

  assign pop_ready_o = !busy_q || done;
  assign load        = pop_valid_i && pop_ready_o;

  assign out_o.valid      = busy_q;
  assign out_o.token_kind = tok.kind;
  assign out_o.token_char = tok.ch;
  assign out_o.last       = is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= pop_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (out_fire) begin
      idx_q <= idx_q + 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cur_q.n != '0 && cts_pkg::TOK_CNT_W'(idx_q) < cur_q.n)
    else $error("token index past bundle size");
  a_idx_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !is_last |=> busy_q && idx_q == $past(idx_q) + 1'b1)
    else $error("token skipped or repeated");
`endif

endmodule

`default_nettype wire

/* design/calculator_token_scanner.sv */
// a character's tokens are written to the bundle queue when the character is transferred,
// then loaded from the queue into the output stage before the first of them is offered
// throughput: one character per cycle while the bundle queue has room; tokens leave at
// one per cycle while the output is ready, so a character giving k tokens needs k transfers
// the queue holds QueueDepth bundles of up to four tokens between scanner and output
// reset (async, active low): scanner returns to idle, queue empties, output valid drops
`default_nettype none

module calculator_token_scanner #(
  parameter int QueueDepth = cts_pkg::QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cts_in_if.sink    in_i,
  cts_out_if.source out_o
);

  logic             push_valid, push_ready;
  cts_pkg::bundle_t push_data;
  logic             pop_valid, pop_ready;
  cts_pkg::bundle_t pop_data;

  cts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  cts_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  cts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
